// ===== rtl/core/rc_pulse_throttle_decoder_macros.svh =====
// assertion macros shared by the throttle decoder rtl
// no dependencies; included by files that carry concurrent checks
`ifndef RC_PULSE_THROTTLE_DECODER_MACROS_SVH
`define RC_PULSE_THROTTLE_DECODER_MACROS_SVH

// same-cycle implication under active-low reset
`define RPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under active-low reset
`define RPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rpt_pkg.sv =====
// types and constants for the rc pulse throttle decoder
// no dependencies; used by the interfaces and all modules
`timescale 1ns / 1ps
`default_nettype none

package rpt_pkg;

  localparam int TS_W      = 32;
  localparam int LEN_W     = 12;
  localparam int THR_W     = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int ERR_OUT_W = 16;
  localparam int DIFF_W    = 10;
  localparam int RECIP_W   = 26;
  localparam int PROD_W    = DIFF_W + RECIP_W;
  localparam int FRAC_SH   = 20;
  localparam int QUO_W     = 11;
  localparam int SUM_W     = THR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VALID = 2'd0,
    CFG_MAX_VALID = 2'd1,
    CFG_MIN_DUTY  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PROTO_NONE  = 2'd0,
    PROTO_PWM   = 2'd1,
    PROTO_OS125 = 2'd2,
    PROTO_OS42  = 2'd3
  } proto_e;

  localparam logic [CFG_W-1:0] MIN_VALID_RST = 12'd20;
  localparam logic [CFG_W-1:0] MAX_VALID_RST = 12'd2500;
  localparam logic [CFG_W-1:0] MIN_DUTY_RST  = 12'd400;

  localparam logic [LEN_W-1:0] PWM_DETECT   = 12'd750;
  localparam logic [LEN_W-1:0] OS125_DETECT = 12'd100;
  localparam logic [LEN_W-1:0] OS42_DETECT  = 12'd30;

  localparam logic [LEN_W-1:0] PWM_BASE   = 12'd1000;
  localparam logic [LEN_W-1:0] PWM_TOP    = 12'd2000;
  localparam logic [LEN_W-1:0] OS125_BASE = 12'd125;
  localparam logic [LEN_W-1:0] OS125_TOP  = 12'd250;
  localparam logic [LEN_W-1:0] OS42_BASE  = 12'd42;
  localparam logic [LEN_W-1:0] OS42_TOP   = 12'd84;

  // ceil(1648 * 2^20 / range), exact floor over each full span
  localparam logic [RECIP_W-1:0] PWM_RECIP   = 26'd1728054;
  localparam logic [RECIP_W-1:0] OS125_RECIP = 26'd13824426;
  localparam logic [RECIP_W-1:0] OS42_RECIP  = 26'd41144125;

  localparam logic [SUM_W-1:0] DUTY_MAX = 13'd2048;

  typedef struct packed {
    logic            edge_rising;
    logic [TS_W-1:0] timestamp_us;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_valid_pulse_us;
    logic [CFG_W-1:0] max_valid_pulse_us;
    logic [CFG_W-1:0] min_throttle_duty;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpt_edge_if.sv =====
// valid/ready channel carrying timestamped command edges
// depends on rpt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rpt_edge_if;
  logic                      valid;
  logic                      ready;
  logic                      edge_rising;
  logic [rpt_pkg::TS_W-1:0]  timestamp_us;

  modport source (output valid, output edge_rising, output timestamp_us, input ready);
  modport sink   (input valid, input edge_rising, input timestamp_us, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rpt_result_if.sv =====
// valid/ready channel carrying decoded throttle results
// depends on rpt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rpt_result_if;
  logic                          valid;
  logic                          ready;
  logic [rpt_pkg::THR_W-1:0]     throttle;
  logic                          throttle_updated;
  logic                          pulse_error;
  logic [1:0]                    protocol;
  logic [rpt_pkg::ERR_OUT_W-1:0] error_count;
  logic [rpt_pkg::TS_W-1:0]      last_ok_time_us;

  modport source (output valid, output throttle, output throttle_updated,
                  output pulse_error, output protocol, output error_count,
                  output last_ok_time_us, input ready);
  modport sink   (input valid, input throttle, input throttle_updated,
                  input pulse_error, input protocol, input error_count,
                  input last_ok_time_us, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rc_pulse_throttle_decoder.sv =====
// an accepted item goes through the input register, then the result register in rpt_core
// throughput: 1 item per cycle while the result channel is ready; set by the state update loop in rpt_core
// results wait in an output register while the input register takes the next item
// reset: async active low; clears state except the input item data, loads register defaults
// no memories, so there is no clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_throttle_decoder #(
  parameter int TIME_WIDTH        = 32,
  parameter int ERROR_COUNT_WIDTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rpt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rpt_pkg::CFG_W-1:0]       cfg_data_i,
  rpt_edge_if.sink                             edge_if,
  rpt_result_if.source                         result_if
);

  rpt_pkg::cfg_t  cfg_q, cfg_d;
  rpt_pkg::item_t item;
  logic           item_valid;
  logic           take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (rpt_pkg::cfg_idx_e'(cfg_idx_i))
        rpt_pkg::CFG_MIN_VALID: cfg_d.min_valid_pulse_us = cfg_data_i;
        rpt_pkg::CFG_MAX_VALID: cfg_d.max_valid_pulse_us = cfg_data_i;
        rpt_pkg::CFG_MIN_DUTY:  cfg_d.min_throttle_duty  = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_valid_pulse_us <= rpt_pkg::MIN_VALID_RST;
      cfg_q.max_valid_pulse_us <= rpt_pkg::MAX_VALID_RST;
      cfg_q.min_throttle_duty  <= rpt_pkg::MIN_DUTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rpt_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .edge_if      (edge_if),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  rpt_core #(
    .TIME_WIDTH        (TIME_WIDTH),
    .ERROR_COUNT_WIDTH (ERROR_COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .take_o       (take),
    .result_if    (result_if)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rpt_in_stage.sv =====
// input register for edge items
// depends on rpt_pkg and rpt_edge_if
`timescale 1ns / 1ps
`default_nettype none

module rpt_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  rpt_edge_if.sink            edge_if,
  input  wire logic           take_i,
  output      logic           item_valid_o,
  output      rpt_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  logic           load;
  rpt_pkg::item_t item_q;

  assign edge_if.ready = !valid_q || take_i;
  assign load          = edge_if.valid && edge_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.edge_rising  <= edge_if.edge_rising;
      item_q.timestamp_us <= edge_if.timestamp_us;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/rpt_core.sv =====
// pulse measurement, classification, throttle mapping, state and result register
// depends on rpt_pkg, rpt_result_if and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "rc_pulse_throttle_decoder_macros.svh"

module rpt_core #(
  parameter int TIME_WIDTH        = 32,
  parameter int ERROR_COUNT_WIDTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire rpt_pkg::item_t item_i,
  input  wire rpt_pkg::cfg_t  cfg_i,
  output      logic           take_o,
  rpt_result_if.source        result_if
);

  logic [TIME_WIDTH-1:0]        rise_q, rise_d;
  logic [TIME_WIDTH-1:0]        good_time_q, good_time_d;
  logic [rpt_pkg::LEN_W-1:0]    cur_len_q, cur_len_d;
  logic [rpt_pkg::THR_W-1:0]    thr_q, thr_d;
  logic [ERROR_COUNT_WIDTH-1:0] err_cnt_q, err_cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         upd_q, upd_d;
  logic                         perr_q, perr_d;
  rpt_pkg::proto_e              proto_q, proto_d;

  logic [TIME_WIDTH-1:0]        ts;
  logic [TIME_WIDTH-1:0]        len;
  logic [rpt_pkg::LEN_W-1:0]    len12;
  logic                         in_window;
  rpt_pkg::proto_e              cls;
  logic [rpt_pkg::LEN_W-1:0]    base, top, clamped;
  logic [rpt_pkg::RECIP_W-1:0]  recip;
  logic [rpt_pkg::DIFF_W-1:0]   diff;
  logic [rpt_pkg::PROD_W-1:0]   prod;
  logic [rpt_pkg::QUO_W-1:0]    quo;
  logic [rpt_pkg::SUM_W-1:0]    sum;
  logic [rpt_pkg::THR_W-1:0]    mapped;

  assign take_o = item_valid_i && (!out_valid_q || result_if.ready);

  if (TIME_WIDTH > rpt_pkg::TS_W) begin : g_ts_ext
    assign ts = {{(TIME_WIDTH - rpt_pkg::TS_W){1'b0}}, item_i.timestamp_us};
    assign result_if.last_ok_time_us = good_time_q[rpt_pkg::TS_W-1:0];
  end else if (TIME_WIDTH == rpt_pkg::TS_W) begin : g_ts_eq
    assign ts = item_i.timestamp_us;
    assign result_if.last_ok_time_us = good_time_q;
  end else begin : g_ts_cut
    assign ts = item_i.timestamp_us[TIME_WIDTH-1:0];
    assign result_if.last_ok_time_us =
      {{(rpt_pkg::TS_W - TIME_WIDTH){1'b0}}, good_time_q};
  end

  if (ERROR_COUNT_WIDTH > rpt_pkg::ERR_OUT_W) begin : g_err_cut
    assign result_if.error_count = err_cnt_q[rpt_pkg::ERR_OUT_W-1:0];
  end else if (ERROR_COUNT_WIDTH == rpt_pkg::ERR_OUT_W) begin : g_err_eq
    assign result_if.error_count = err_cnt_q;
  end else begin : g_err_ext
    assign result_if.error_count =
      {{(rpt_pkg::ERR_OUT_W - ERROR_COUNT_WIDTH){1'b0}}, err_cnt_q};
  end

  assign len       = ts - rise_q;
  assign len12     = len[rpt_pkg::LEN_W-1:0];
  assign in_window =
    (len >= {{(TIME_WIDTH - rpt_pkg::CFG_W){1'b0}}, cfg_i.min_valid_pulse_us}) &&
    (len <= {{(TIME_WIDTH - rpt_pkg::CFG_W){1'b0}}, cfg_i.max_valid_pulse_us});

  // protocol detect and span selection
  always_comb begin
    cls   = rpt_pkg::PROTO_NONE;
    base  = '0;
    top   = '0;
    recip = '0;
    if (len12 > rpt_pkg::PWM_DETECT) begin
      cls   = rpt_pkg::PROTO_PWM;
      base  = rpt_pkg::PWM_BASE;
      top   = rpt_pkg::PWM_TOP;
      recip = rpt_pkg::PWM_RECIP;
    end else if (len12 > rpt_pkg::OS125_DETECT) begin
      cls   = rpt_pkg::PROTO_OS125;
      base  = rpt_pkg::OS125_BASE;
      top   = rpt_pkg::OS125_TOP;
      recip = rpt_pkg::OS125_RECIP;
    end else if (len12 > rpt_pkg::OS42_DETECT) begin
      cls   = rpt_pkg::PROTO_OS42;
      base  = rpt_pkg::OS42_BASE;
      top   = rpt_pkg::OS42_TOP;
      recip = rpt_pkg::OS42_RECIP;
    end
  end

  // clamp, scale by reciprocal, add floor, saturate; zero at the span base
  always_comb begin
    logic [rpt_pkg::LEN_W-1:0] span;
    span = '0;
    if (len12 < base) begin
      clamped = base;
    end else if (len12 > top) begin
      clamped = top;
    end else begin
      clamped = len12;
    end
    span   = clamped - base;
    diff   = span[rpt_pkg::DIFF_W-1:0];
    prod   = {{rpt_pkg::RECIP_W{1'b0}}, diff} * {{rpt_pkg::DIFF_W{1'b0}}, recip};
    quo    = prod[rpt_pkg::FRAC_SH +: rpt_pkg::QUO_W];
    sum    = {1'b0, cfg_i.min_throttle_duty} + {2'b00, quo};
    if (diff == '0) begin
      mapped = '0;
    end else if (sum > rpt_pkg::DUTY_MAX) begin
      mapped = rpt_pkg::DUTY_MAX[rpt_pkg::THR_W-1:0];
    end else begin
      mapped = sum[rpt_pkg::THR_W-1:0];
    end
  end

  // state update for one item
  always_comb begin
    rise_d      = rise_q;
    good_time_d = good_time_q;
    cur_len_d   = cur_len_q;
    thr_d       = thr_q;
    err_cnt_d   = err_cnt_q;
    upd_d       = upd_q;
    perr_d      = perr_q;
    proto_d     = proto_q;
    out_valid_d = out_valid_q;
    if (result_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (take_o) begin
      out_valid_d = 1'b1;
      upd_d       = 1'b0;
      perr_d      = 1'b0;
      proto_d     = rpt_pkg::PROTO_NONE;
      if (item_i.edge_rising) begin
        rise_d = ts;
      end else if (in_window) begin
        cur_len_d   = len12;
        good_time_d = ts;
        if (len12 != cur_len_q) begin
          if (cls == rpt_pkg::PROTO_NONE) begin
            perr_d = 1'b1;
            if (!(&err_cnt_q)) begin
              err_cnt_d = err_cnt_q + 1'b1;
            end
          end else begin
            proto_d = cls;
            thr_d   = mapped;
            upd_d   = 1'b1;
          end
        end
      end else begin
        perr_d = 1'b1;
        if (!(&err_cnt_q)) begin
          err_cnt_d = err_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q      <= '0;
      good_time_q <= '0;
      cur_len_q   <= '0;
      thr_q       <= '0;
      err_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      upd_q       <= 1'b0;
      perr_q      <= 1'b0;
      proto_q     <= rpt_pkg::PROTO_NONE;
    end else begin
      rise_q      <= rise_d;
      good_time_q <= good_time_d;
      cur_len_q   <= cur_len_d;
      thr_q       <= thr_d;
      err_cnt_q   <= err_cnt_d;
      out_valid_q <= out_valid_d;
      upd_q       <= upd_d;
      perr_q      <= perr_d;
      proto_q     <= proto_d;
    end
  end

  assign result_if.valid            = out_valid_q;
  assign result_if.throttle         = thr_q;
  assign result_if.throttle_updated = upd_q;
  assign result_if.pulse_error      = perr_q;
  assign result_if.protocol         = proto_q;

  `RPT_ASSERT_NOW(a_upd_perr_excl, clk_i, rst_ni, out_valid_q, !(upd_q && perr_q),
    "update and pulse error in one item")
  `RPT_ASSERT_NOW(a_proto_with_upd, clk_i, rst_ni, out_valid_q,
    (proto_q != rpt_pkg::PROTO_NONE) == upd_q, "protocol reported without update")
  `RPT_ASSERT_NOW(a_thr_bound, clk_i, rst_ni, 1'b1,
    {1'b0, thr_q} <= rpt_pkg::DUTY_MAX, "throttle above full scale")
  `RPT_ASSERT_NEXT(a_err_mono, clk_i, rst_ni, take_o, err_cnt_q >= $past(err_cnt_q),
    "error count went down")

endmodule

`default_nettype wire
